### hw/rtl/brrm_pkg.sv
// Shared types, constants and codes for the block range reservation map.
package brrm_pkg;

   localparam int MAX_BLOCKS = 64;
   localparam int ADDR_BITS  = 52;

   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int BLK_W      = 7;
   localparam int LG_W       = 6;
   localparam int USERS_W    = 7;
   localparam int STATUS_W   = 3;
   localparam int REQ_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = ADDR_BITS;

   localparam int LOG2_MIN   = 12;
   localparam int LOG2_MAX   = 40;
   localparam int USER_LIMIT = 64;

   // Window span is at most (2^BLK_W - 1) << LOG2_MAX; keep one spare bit for the end sum.
   localparam int SPAN_W     = BLK_W + LOG2_MAX;
   localparam int END_W      = ((ADDR_BITS > SPAN_W) ? ADDR_BITS : SPAN_W) + 1;

   localparam logic [REQ_W-1:0] REQ_COMMIT   = REQ_W'(0);
   localparam logic [REQ_W-1:0] REQ_UNCOMMIT = REQ_W'(1);
   localparam logic [REQ_W-1:0] REQ_RELEASE  = REQ_W'(2);

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_BASE     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_BLOCKS   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE_LOG2 = CSR_IDX_W'(2);

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_RANGE     = 3'd1,
      ST_CONFLICT  = 3'd2,
      ST_UNUSED    = 3'd3,
      ST_NOT_EXACT = 3'd4,
      ST_BUSY      = 3'd5,
      ST_RELEASED  = 3'd6
   } status_type;

   // What the back end has to do with a classified request.
   typedef enum logic [2:0] {
      K_RANGE     = 3'd0,
      K_NOT_EXACT = 3'd1,
      K_RELEASE   = 3'd2,
      K_COMMIT    = 3'd3,
      K_UNCOMMIT  = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic [IDX_W-1:0] lo;
      logic [IDX_W-1:0] hi;
   } cmd_type;

   typedef struct packed {
      status_type            status;
      logic [USERS_W-1:0]    users_now;
      logic [MAX_BLOCKS-1:0] occupied_map;
   } rsp_type;

endpackage

### hw/rtl/brrm_front.sv
// Front end: window configuration registers and request classification.
module brrm_front import brrm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [REQ_W-1:0]      req_type,
   input  logic [ADDR_BITS-1:0]  req_start_addr,
   input  logic [ADDR_BITS-1:0]  req_end_addr,
   output cmd_type               cmd
);

   logic [ADDR_BITS-1:0] base_ff;
   logic [BLK_W-1:0]     blocks_ff;
   logic [LG_W-1:0]      lg_ff;

   logic [BLK_W-1:0]     blocks_eff;
   logic [LG_W-1:0]      lg_eff;
   logic [END_W-1:0]     span;
   logic [END_W-1:0]     win_end;
   logic [ADDR_BITS-1:0] s_off;
   logic [ADDR_BITS-1:0] e_off;
   logic                 range_bad;
   logic                 exact;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         blocks_ff <= BLK_W'(1);
         lg_ff     <= LG_W'(27);
      end else if (csr_wr_en) begin
         if (csr_index == CSR_WINDOW_BASE) begin
            base_ff <= csr_wdata;
         end
         if (csr_index == CSR_WINDOW_BLOCKS) begin
            blocks_ff <= csr_wdata[BLK_W-1:0];
         end
         if (csr_index == CSR_BLOCK_SIZE_LOG2) begin
            lg_ff <= csr_wdata[LG_W-1:0];
         end
      end
   end

   // Clamp out-of-range settings.
   always_comb begin
      blocks_eff = blocks_ff;
      if (blocks_ff == '0) begin
         blocks_eff = BLK_W'(1);
      end else if (blocks_ff > BLK_W'(MAX_BLOCKS)) begin
         blocks_eff = BLK_W'(MAX_BLOCKS);
      end
      lg_eff = lg_ff;
      if (lg_ff < LG_W'(LOG2_MIN)) begin
         lg_eff = LG_W'(LOG2_MIN);
      end else if (lg_ff > LG_W'(LOG2_MAX)) begin
         lg_eff = LG_W'(LOG2_MAX);
      end
   end

   assign span    = END_W'(blocks_eff) << lg_eff;
   assign win_end = END_W'(base_ff) + span - END_W'(1);
   assign s_off   = req_start_addr - base_ff;
   assign e_off   = req_end_addr - base_ff;

   assign range_bad = (req_start_addr > req_end_addr) || (req_start_addr < base_ff) ||
                      (END_W'(req_end_addr) > win_end);
   assign exact     = (req_start_addr == base_ff) && (END_W'(req_end_addr) == win_end);

   always_comb begin
      cmd.lo = IDX_W'(s_off >> lg_eff);
      cmd.hi = IDX_W'(e_off >> lg_eff);
      priority if (req_type == REQ_RELEASE) begin
         cmd.kind = exact ? K_RELEASE : K_NOT_EXACT;
      end else if (req_type != REQ_COMMIT && req_type != REQ_UNCOMMIT) begin
         cmd.kind = K_RANGE;
      end else if (range_bad) begin
         cmd.kind = K_RANGE;
      end else if (req_type == REQ_COMMIT) begin
         cmd.kind = K_COMMIT;
      end else begin
         cmd.kind = K_UNCOMMIT;
      end
   end

endmodule

### hw/rtl/brrm_cmd_queue.sv
// Two-entry queue of classified requests between front and back end.
module brrm_cmd_queue import brrm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type cmd_in,
   output logic    full,
   input  logic    pop,
   output cmd_type cmd_out,
   output logic    empty
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign cmd_out = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

### hw/rtl/brrm_back.sv
// Back end: occupancy map, user count, retire flag and result queue.
module brrm_back import brrm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_empty,
   input  cmd_type cmd,
   output logic    cmd_pop,
   input  logic    pop,
   output logic    empty,
   output rsp_type rsp
);

   logic [MAX_BLOCKS-1:0] occ_ff;
   logic [MAX_BLOCKS-1:0] occ_in;
   logic [USERS_W-1:0]    users_ff;
   logic [USERS_W-1:0]    users_in;
   logic                  retired_ff;
   logic                  retired_in;
   status_type            status;
   logic [MAX_BLOCKS-1:0] mask;

   rsp_type    res_ff [2];
   logic       res_wr_ff;
   logic       res_rd_ff;
   logic [1:0] res_cnt_ff;
   logic [1:0] res_cnt_in;
   logic       res_full;
   logic       rsp_pop;

   assign res_full = (res_cnt_ff == 2'd2);
   assign cmd_pop  = !cmd_empty && !res_full;
   assign empty    = (res_cnt_ff == 2'd0);
   assign rsp_pop  = pop && !empty;
   assign rsp      = res_ff[res_rd_ff];

   assign mask = ({MAX_BLOCKS{1'b1}} >> (IDX_W'(MAX_BLOCKS - 1) - cmd.hi)) &
                 ({MAX_BLOCKS{1'b1}} << cmd.lo);

   always_comb begin
      occ_in     = occ_ff;
      users_in   = users_ff;
      retired_in = retired_ff;
      status     = ST_OK;
      if (retired_ff) begin
         status = ST_RELEASED;
      end else begin
         unique case (cmd.kind)
            K_RANGE:     status = ST_RANGE;
            K_NOT_EXACT: status = ST_NOT_EXACT;
            K_RELEASE: begin
               if (users_ff != '0) begin
                  status = ST_BUSY;
               end else begin
                  occ_in     = '0;
                  retired_in = 1'b1;
               end
            end
            K_COMMIT: begin
               if ((occ_ff & mask) != '0) begin
                  status = ST_CONFLICT;
               end else begin
                  occ_in = occ_ff | mask;
                  if (users_ff < USERS_W'(USER_LIMIT)) begin
                     users_in = users_ff + USERS_W'(1);
                  end
               end
            end
            K_UNCOMMIT: begin
               if ((occ_ff & mask) != mask) begin
                  status = ST_UNUSED;
               end else begin
                  occ_in = occ_ff & ~mask;
                  if (users_ff != '0) begin
                     users_in = users_ff - USERS_W'(1);
                  end
               end
            end
            default:     status = ST_RANGE;
         endcase
      end
   end

   always_comb begin
      res_cnt_in = res_cnt_ff;
      if (cmd_pop && !rsp_pop) begin
         res_cnt_in = res_cnt_ff + 2'd1;
      end else if (rsp_pop && !cmd_pop) begin
         res_cnt_in = res_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff     <= '0;
         users_ff   <= '0;
         retired_ff <= 1'b0;
         res_wr_ff  <= 1'b0;
         res_rd_ff  <= 1'b0;
         res_cnt_ff <= 2'd0;
      end else begin
         res_cnt_ff <= res_cnt_in;
         if (cmd_pop) begin
            occ_ff     <= occ_in;
            users_ff   <= users_in;
            retired_ff <= retired_in;
            res_wr_ff  <= !res_wr_ff;
         end
         if (rsp_pop) begin
            res_rd_ff <= !res_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         res_ff[res_wr_ff] <= '{status: status, users_now: users_in, occupied_map: occ_in};
      end
   end

endmodule

### hw/rtl/block_range_reservation_map_top.sv
// A request transferred into the command queue is registered there, executed from its head and
// registered in the result queue, and only then shows its result on the rsp_ ports.
// Throughput: one request per cycle unless stalled, from the mask test and update in the back end;
// two-entry queues after classification and after execution absorb stalls on either side.
// Reset (synchronous, active high) empties both queues, clears the occupancy map, the user
// count and the retire flag, and loads window_base 0, window_blocks 1, block_size_log2 27.
module block_range_reservation_map_top import brrm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // Configuration writes
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // Request side
   input  logic                  push,
   output logic                  full,
   input  logic [REQ_W-1:0]      req_type,
   input  logic [ADDR_BITS-1:0]  req_start_addr,
   input  logic [ADDR_BITS-1:0]  req_end_addr,
   // Result side
   output logic                  empty,
   input  logic                  pop,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [USERS_W-1:0]    rsp_users_now,
   output logic [MAX_BLOCKS-1:0] rsp_occupied_map
);

   cmd_type front_cmd;
   cmd_type back_cmd;
   logic    cmd_empty;
   logic    cmd_pop;
   rsp_type rsp;

   // Classify each request against the window: range and exact-match checks, block indices.
   brrm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_type       (req_type),
      .req_start_addr (req_start_addr),
      .req_end_addr   (req_end_addr),
      .cmd            (front_cmd)
   );

   // Hold classified requests; full here backpressures the request transfer.
   brrm_cmd_queue u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .cmd_in  (front_cmd),
      .full    (full),
      .pop     (cmd_pop),
      .cmd_out (back_cmd),
      .empty   (cmd_empty)
   );

   // Apply each request to the map and count, then queue its result for the rsp_ side.
   brrm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd       (back_cmd),
      .cmd_pop   (cmd_pop),
      .pop       (pop),
      .empty     (empty),
      .rsp       (rsp)
   );

   // Drive the head of the result queue.
   assign rsp_status       = rsp.status;
   assign rsp_users_now    = rsp.users_now;
   assign rsp_occupied_map = rsp.occupied_map;

endmodule
